// ----- hw/rtl/lbvs_pkg.sv -----
// lbvs_pkg: shared types and constants of the vertex skinning engine
// used by lbvs_front, lbvs_back and the top level
`default_nettype none
package lbvs_pkg;
   localparam int unsigned MatElems = 16;
   localparam logic ActWrite = 1'b0;
   localparam logic ActInfl  = 1'b1;

   typedef struct packed {
      logic        action;
      logic [5:0]  bone_index;
      logic [3:0]  element_index;
      logic [31:0] matrix_value;
      logic [16:0] weight;
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [31:0] pos_z;
      logic [31:0] nrm_x;
      logic [31:0] nrm_y;
      logic [31:0] nrm_z;
      logic        last_influence;
   } item_type;

   typedef struct packed {
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [31:0] pos_z;
      logic [31:0] nrm_x;
      logic [31:0] nrm_y;
      logic [31:0] nrm_z;
   } result_type;

   // saturate to signed 32
   function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
      logic signed [65:0] mx;
      logic signed [65:0] mn;
      begin
         mx = 66'sd2147483647;
         mn = -66'sd2147483648;
         if (x > mx) sat32 = 32'sh7fffffff;
         else if (x < mn) sat32 = 32'sh80000000;
         else sat32 = x[31:0];
      end
   endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/lbvs_front.sv -----
// lbvs_front: input stage and short item queue
// depends on lbvs_pkg
`default_nettype none
module lbvs_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   output logic                   full,
   input  wire lbvs_pkg::item_type in_item,
   output logic                   q_valid,
   input  wire logic              q_take,
   output lbvs_pkg::item_type     q_item
);
   lbvs_pkg::item_type mem_ff [2];
   logic [1:0] count_ff, count_in;
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic       do_push, do_pop;

   assign full    = (count_ff == 2'd2);
   assign q_valid = (count_ff != 2'd0);
   assign q_item  = mem_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop  = q_take && q_valid;

   // pointer and count update
   always_comb begin
      wr_in    = wr_ff ^ do_push;
      rd_in    = rd_ff ^ do_pop;
      count_in = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= in_item;
   end
endmodule
`default_nettype wire

// ----- hw/rtl/lbvs_back.sv -----
// lbvs_back: palette memory, blend accumulator and vertex transform sequencer
// depends on lbvs_pkg
`default_nettype none
module lbvs_back #(
   parameter int unsigned BONE_COUNT = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               q_valid,
   output logic                    q_take,
   input  wire lbvs_pkg::item_type q_item,
   output logic                    rsp_valid,
   input  wire logic               rsp_take,
   output lbvs_pkg::result_type    rsp_data
);
   localparam int unsigned Depth = BONE_COUNT * lbvs_pkg::MatElems;
   localparam int unsigned AW = $clog2(Depth);

   localparam logic [2:0] StIdle = 3'd0;
   localparam logic [2:0] StAcc  = 3'd1;
   localparam logic [2:0] StXfm  = 3'd2;
   localparam logic [2:0] StOut  = 3'd3;

   logic [2:0]  state_ff, state_in;
   logic [4:0]  cnt_ff, cnt_in;
   lbvs_pkg::item_type it_ff;
   logic [31:0] pal_mem [Depth];
   logic [31:0] rd_data_ff;
   logic        rd_v_ff;
   logic [3:0]  rd_k_ff;
   logic [63:0] acc_ff [16];
   logic signed [31:0] res_ff [6];
   logic signed [65:0] sum_ff;
   logic signed [65:0] xsum;
   logic signed [63:0] prod_ff;
   logic        prod_v_ff;
   logic        out_v_ff;
   logic        out_free;
   lbvs_pkg::result_type out_ff;
   logic        bone_ok;
   logic [AW-1:0] addr;
   logic [7:0]  bone8;

   assign bone8   = {2'b00, q_item.bone_index};
   assign bone_ok = ({3'b000, q_item.bone_index} < 9'(BONE_COUNT));
   assign q_take  = (state_ff == StIdle) && q_valid;
   assign out_free  = !out_v_ff || rsp_take;
   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

   // palette address during accumulate sweep
   assign addr = AW'({2'b00, it_ff.bone_index, cnt_ff[3:0]});

   // palette write and read port
   always_ff @(posedge clock) begin
      if (q_take && q_item.action == lbvs_pkg::ActWrite && bone_ok)
         pal_mem[AW'({bone8, q_item.element_index})] <= q_item.matrix_value;
      rd_data_ff <= pal_mem[addr];
   end

   // element of blended matrix as Q16.16
   function automatic logic signed [31:0] elem(input logic [63:0] a);
      elem = lbvs_pkg::sat32(66'(signed'(a) >>> 16));
   endfunction

   // transform step: cnt 0..17, output o = cnt/3 and column c = cnt%3 via small table
   logic [3:0] xk;
   logic signed [31:0] xv;
   logic [2:0] xo;
   logic       xaff, xfirst, xlast;
   always_comb begin
      // step s: output o = s/3, column c = s%3 (18 steps)
      logic [2:0] o;
      logic [1:0] c;
      o = 3'd0; c = 2'd0;
      case (cnt_ff)
         5'd0: begin o = 3'd0; c = 2'd0; end  5'd1: begin o = 3'd0; c = 2'd1; end
         5'd2: begin o = 3'd0; c = 2'd2; end  5'd3: begin o = 3'd1; c = 2'd0; end
         5'd4: begin o = 3'd1; c = 2'd1; end  5'd5: begin o = 3'd1; c = 2'd2; end
         5'd6: begin o = 3'd2; c = 2'd0; end  5'd7: begin o = 3'd2; c = 2'd1; end
         5'd8: begin o = 3'd2; c = 2'd2; end  5'd9: begin o = 3'd3; c = 2'd0; end
         5'd10: begin o = 3'd3; c = 2'd1; end 5'd11: begin o = 3'd3; c = 2'd2; end
         5'd12: begin o = 3'd4; c = 2'd0; end 5'd13: begin o = 3'd4; c = 2'd1; end
         5'd14: begin o = 3'd4; c = 2'd2; end 5'd15: begin o = 3'd5; c = 2'd0; end
         5'd16: begin o = 3'd5; c = 2'd1; end 5'd17: begin o = 3'd5; c = 2'd2; end
         default: begin o = 3'd0; c = 2'd0; end
      endcase
      xo = o;
      xaff = (o < 3'd3);
      xfirst = (c == 2'd0);
      xlast = (c == 2'd2);
      xk = 4'({(xaff ? o[1:0] : 2'(o - 3'd3)), c});
      case ({xaff, c})
         3'b100: xv = it_ff.pos_x;
         3'b101: xv = it_ff.pos_y;
         3'b110: xv = it_ff.pos_z;
         3'b000: xv = it_ff.nrm_x;
         3'b001: xv = it_ff.nrm_y;
         3'b010: xv = it_ff.nrm_z;
         default: xv = 32'sd0;
      endcase
   end

   // multiply stage tags registered with the product; pk_ff is registered for the accumulate path too
   logic [2:0] po_ff;
   logic       paff_ff, pfirst_ff, plast_ff;
   logic [3:0] pk_ff;

   // running row sum, translation added on the last column of a position row
   always_comb begin
      xsum = (pfirst_ff ? 66'sd0 : sum_ff) + 66'(prod_ff >>> 16);
      if (plast_ff && paff_ff) xsum = xsum + 66'(elem(acc_ff[pk_ff]));
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         StIdle: begin
            cnt_in = 5'd0;
            if (q_take && q_item.action == lbvs_pkg::ActInfl) begin
               if (bone_ok) state_in = StAcc;
               else if (q_item.last_influence) state_in = StXfm;
            end
         end
         StAcc: begin
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd18) begin
               cnt_in = 5'd0;
               state_in = it_ff.last_influence ? StXfm : StIdle;
            end
         end
         StXfm: begin
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd20) state_in = StOut;
         end
         StOut: if (out_free) state_in = StIdle;
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         cnt_ff   <= 5'd0;
         rd_v_ff  <= 1'b0;
         prod_v_ff <= 1'b0;
         out_v_ff <= 1'b0;
         for (int i = 0; i < 16; i++) acc_ff[i] <= 64'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (q_take) it_ff <= q_item;
         // palette read data is registered and returns in the following cycle
         rd_v_ff <= (state_ff == StAcc) && (cnt_ff < 5'd16);
         rd_k_ff <= cnt_ff[3:0];
         // shared multiplier: blended element times coordinate, or weight times word
         if (state_ff == StXfm) begin
            prod_v_ff <= (cnt_ff < 5'd18);
            prod_ff <= 64'(elem(acc_ff[xk])) * 64'(xv);
            po_ff <= xo; paff_ff <= xaff; pfirst_ff <= xfirst; plast_ff <= xlast;
            pk_ff <= 4'({xo[1:0], 2'd3});
         end else begin
            prod_v_ff <= rd_v_ff && (state_ff == StAcc);
            prod_ff <= 64'(signed'(rd_data_ff)) * signed'({47'd0, it_ff.weight});
            pk_ff <= rd_k_ff;
         end
         // accumulator update, cleared after the transform
         if (state_ff == StXfm && cnt_ff == 5'd20) begin
            for (int i = 0; i < 16; i++) acc_ff[i] <= 64'd0;
         end else if (prod_v_ff && state_ff == StAcc) begin
            acc_ff[pk_ff] <= acc_ff[pk_ff] + prod_ff;
         end
         // row sums and saturated outputs
         if (state_ff == StXfm && prod_v_ff) begin
            sum_ff <= xsum;
            if (plast_ff) res_ff[po_ff] <= lbvs_pkg::sat32(xsum);
         end
         // output register, refilled in the cycle it is popped
         if (state_ff == StOut && out_free) begin
            out_ff   <= {res_ff[0], res_ff[1], res_ff[2], res_ff[3], res_ff[4], res_ff[5]};
            out_v_ff <= 1'b1;
         end else if (out_v_ff && rsp_take) begin
            out_v_ff <= 1'b0;
         end
      end
   end
endmodule
`default_nettype wire

// ----- hw/rtl/linear_blend_vertex_skinning_top.sv -----
// linear_blend_vertex_skinning_top: vertex skinning engine top level
// depends on lbvs_pkg, lbvs_front, lbvs_back
//
//  channel   ports            accepted when
//  input     req_*, push      push && !full
//  result    rsp_*, pop       pop && !empty
//
// an item waits in the two-entry front queue until the idle back end takes it.
// back end: a palette write is done in the idle state; an influence reads its
// bone's sixteen palette words from the palette memory one per cycle; a last
// influence then runs the transform and loads the output register.
// reset clears queue, sequencer, accumulator and output; the palette is not cleared.
// a waiting result holds the back end only when the next result is ready to load.
`default_nettype none
module linear_blend_vertex_skinning_top #(
   parameter int unsigned BONE_COUNT = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic        req_action,
   input  wire logic [5:0]  req_bone_index,
   input  wire logic [3:0]  req_element_index,
   input  wire logic [31:0] req_matrix_value,
   input  wire logic [16:0] req_weight,
   input  wire logic [31:0] req_pos_x,
   input  wire logic [31:0] req_pos_y,
   input  wire logic [31:0] req_pos_z,
   input  wire logic [31:0] req_nrm_x,
   input  wire logic [31:0] req_nrm_y,
   input  wire logic [31:0] req_nrm_z,
   input  wire logic        req_last_influence,
   output logic             empty,
   input  wire logic        pop,
   output logic [31:0]      rsp_out_pos_x,
   output logic [31:0]      rsp_out_pos_y,
   output logic [31:0]      rsp_out_pos_z,
   output logic [31:0]      rsp_out_nrm_x,
   output logic [31:0]      rsp_out_nrm_y,
   output logic [31:0]      rsp_out_nrm_z
);
   lbvs_pkg::item_type   in_item, q_item;
   lbvs_pkg::result_type res;
   logic q_valid, q_take, rvalid;

   assign in_item = {req_action, req_bone_index, req_element_index, req_matrix_value,
                     req_weight, req_pos_x, req_pos_y, req_pos_z, req_nrm_x,
                     req_nrm_y, req_nrm_z, req_last_influence};

   lbvs_front u_front (
      .clock(clock), .reset(reset), .push(push), .full(full), .in_item(in_item),
      .q_valid(q_valid), .q_take(q_take), .q_item(q_item)
   );

   lbvs_back #(.BONE_COUNT(BONE_COUNT)) u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_take(q_take),
      .q_item(q_item), .rsp_valid(rvalid), .rsp_take(pop), .rsp_data(res)
   );

   assign empty = !rvalid;
   assign rsp_out_pos_x = res.pos_x;
   assign rsp_out_pos_y = res.pos_y;
   assign rsp_out_pos_z = res.pos_z;
   assign rsp_out_nrm_x = res.nrm_x;
   assign rsp_out_nrm_y = res.nrm_y;
   assign rsp_out_nrm_z = res.nrm_z;
endmodule
`default_nettype wire
